FILE: rtl/core/urtf_pkg.sv
// Shared types and constants for the UART receive and transmit byte FIFOs.
package urtf_pkg;

  // Default FIFO depths in bytes.
  localparam int DEF_RX_DEPTH = 256;
  localparam int DEF_TX_DEPTH = 256;

  // Width of the command field and of the reported levels.
  localparam int CMD_W   = 3;
  localparam int LEVEL_W = 9;

  // Command codes carried on the input channel.
  typedef enum logic [CMD_W-1:0] {
    CMD_RX_BYTE   = 3'd0,
    CMD_TX_READY  = 3'd1,
    CMD_PUSH_BYTE = 3'd2,
    CMD_PUSH_WORD = 3'd3,
    CMD_POP_BYTE  = 3'd4,
    CMD_POP_WORD  = 3'd5,
    CMD_QUERY     = 3'd6
  } cmd_t;

  // Status codes carried on the result channel.
  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_ACCESS,
    S_OUT
  } seq_state_t;

  // One memory access request toward a FIFO.
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_req_t;

endpackage

FILE: rtl/core/urtf_ram.sv
// Byte-wide synchronous memory with one write port and one registered read port.
module urtf_ram import urtf_pkg::*; #(
  parameter int DEPTH = DEF_RX_DEPTH,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/urtf_ptrs.sv
// Write slot, read slot and fill count of one FIFO.
module urtf_ptrs import urtf_pkg::*; #(
  parameter int DEPTH = DEF_RX_DEPTH,
  localparam int AW   = $clog2(DEPTH),
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  fifo_req_t     req,
  output logic [AW-1:0] wr_slot,
  output logic [AW-1:0] rd_slot,
  output logic [CW-1:0] count
);

  logic [AW-1:0] wr_slot_r, wr_slot_nxt;
  logic [AW-1:0] rd_slot_r, rd_slot_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // Slots wrap at the depth, which need not be a power of two.
  always_comb begin
    wr_slot_nxt = wr_slot_r;
    rd_slot_nxt = rd_slot_r;
    count_nxt   = count_r;
    if (req.push) begin
      wr_slot_nxt = (wr_slot_r == AW'(DEPTH - 1)) ? '0 : wr_slot_r + 1'b1;
    end
    if (req.pop) begin
      rd_slot_nxt = (rd_slot_r == AW'(DEPTH - 1)) ? '0 : rd_slot_r + 1'b1;
    end
    if (req.push && !req.pop) begin
      count_nxt = count_r + 1'b1;
    end else if (req.pop && !req.push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_slot_r <= '0;
      rd_slot_r <= '0;
      count_r   <= '0;
    end else begin
      wr_slot_r <= wr_slot_nxt;
      rd_slot_r <= rd_slot_nxt;
      count_r   <= count_nxt;
    end
  end

  assign wr_slot = wr_slot_r;
  assign rd_slot = rd_slot_r;
  assign count   = count_r;

endmodule

FILE: rtl/core/urtf_seq.sv
// Command sequencer: checks room, issues byte accesses and builds the result word.
module urtf_seq import urtf_pkg::*; #(
  parameter int RX_DEPTH = DEF_RX_DEPTH,
  parameter int TX_DEPTH = DEF_TX_DEPTH,
  localparam int RCW     = $clog2(RX_DEPTH + 1),
  localparam int TCW     = $clog2(TX_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [31:0]        in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [31:0]        out_read_data,
  output logic               out_tx_valid,
  output logic [7:0]         out_tx_byte,
  output logic               out_tx_irq_enable,
  output logic [LEVEL_W-1:0] out_rx_level,
  output logic [LEVEL_W-1:0] out_tx_level,
  input  logic [RCW-1:0]     rx_count,
  input  logic [TCW-1:0]     tx_count,
  input  logic [7:0]         rx_q,
  input  logic [7:0]         tx_q,
  output fifo_req_t          rx_req,
  output fifo_req_t          tx_req,
  output logic [7:0]         wr_byte
);

  seq_state_t state_r, state_nxt;
  cmd_t       cmd_r, cmd_nxt;
  status_t    status_r, status_nxt;
  logic [31:0] sh_r, sh_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [1:0]  beat_r, beat_nxt;
  logic [1:0]  last_r, last_nxt;
  logic        rd_pend_r, rd_pend_nxt;
  logic        tx_idle_r, tx_idle_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [31:0]        out_read_data_r, out_read_data_nxt;
  logic               out_tx_valid_r, out_tx_valid_nxt;
  logic [7:0]         out_tx_byte_r, out_tx_byte_nxt;
  logic               out_tx_irq_enable_r, out_tx_irq_enable_nxt;
  logic [LEVEL_W-1:0] out_rx_level_r, out_rx_level_nxt;
  logic [LEVEL_W-1:0] out_tx_level_r, out_tx_level_nxt;

  cmd_t        cmd_in;
  status_t     dec_status;
  logic        dec_access;
  logic [1:0]  dec_last;
  logic [31:0] dec_word;
  logic        accept;
  logic        slot_free;
  logic [7:0]  rd_q;
  logic        is_pop;

  assign cmd_in    = cmd_t'(in_command);
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign rd_q      = (cmd_r == CMD_TX_READY) ? tx_q : rx_q;
  assign is_pop    = (cmd_r == CMD_POP_BYTE) || (cmd_r == CMD_POP_WORD);
  assign wr_byte   = sh_r[31:24];

  // Decode the incoming command against the current fill counts.
  always_comb begin
    dec_status = STAT_DONE;
    dec_access = 1'b0;
    dec_last   = 2'd0;
    dec_word   = in_data;
    unique case (cmd_in)
      CMD_RX_BYTE: begin
        if (rx_count == RCW'(RX_DEPTH)) begin
          dec_status = STAT_FULL;
        end else begin
          dec_access = 1'b1;
          dec_word   = {in_data[7:0], 24'h0};
        end
      end
      CMD_TX_READY: begin
        if (tx_count == '0) begin
          dec_status = STAT_EMPTY;
        end else begin
          dec_access = 1'b1;
        end
      end
      CMD_PUSH_BYTE: begin
        if (tx_count == TCW'(TX_DEPTH)) begin
          dec_status = STAT_FULL;
        end else begin
          dec_access = 1'b1;
          dec_word   = {in_data[7:0], 24'h0};
        end
      end
      CMD_PUSH_WORD: begin
        if (tx_count > TCW'(TX_DEPTH - 4)) begin
          dec_status = STAT_FULL;
        end else begin
          dec_access = 1'b1;
          dec_last   = 2'd3;
        end
      end
      CMD_POP_BYTE: begin
        if (rx_count == '0) begin
          dec_status = STAT_EMPTY;
        end else begin
          dec_access = 1'b1;
        end
      end
      CMD_POP_WORD: begin
        if (rx_count < RCW'(4)) begin
          dec_status = STAT_EMPTY;
        end else begin
          dec_access = 1'b1;
          dec_last   = 2'd3;
        end
      end
      default: begin
      end
    endcase
  end

  // Next state, memory requests and result assembly.
  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    status_nxt  = status_r;
    sh_nxt      = sh_r;
    beat_nxt    = beat_r;
    last_nxt    = last_r;
    tx_idle_nxt = tx_idle_r;
    rd_pend_nxt = 1'b0;
    rx_req      = '0;
    tx_req      = '0;
    // A byte read in the previous cycle is shifted in below the older ones.
    acc_nxt     = rd_pend_r ? {acc_r[23:0], rd_q} : acc_r;

    out_valid_nxt         = out_valid_r && out_stall;
    out_status_nxt        = out_status_r;
    out_read_data_nxt     = out_read_data_r;
    out_tx_valid_nxt      = out_tx_valid_r;
    out_tx_byte_nxt       = out_tx_byte_r;
    out_tx_irq_enable_nxt = out_tx_irq_enable_r;
    out_rx_level_nxt      = out_rx_level_r;
    out_tx_level_nxt      = out_tx_level_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt    = cmd_in;
          status_nxt = dec_status;
          sh_nxt     = dec_word;
          last_nxt   = dec_last;
          beat_nxt   = 2'd0;
          acc_nxt    = '0;
          if (cmd_in == CMD_TX_READY) begin
            tx_idle_nxt = (dec_status != STAT_DONE);
          end else if ((cmd_in == CMD_PUSH_BYTE || cmd_in == CMD_PUSH_WORD) &&
                       dec_status == STAT_DONE) begin
            tx_idle_nxt = 1'b0;
          end
          state_nxt = dec_access ? S_ACCESS : S_OUT;
        end
      end
      S_ACCESS: begin
        unique case (cmd_r)
          CMD_RX_BYTE: begin
            rx_req.push = 1'b1;
          end
          CMD_PUSH_BYTE, CMD_PUSH_WORD: begin
            tx_req.push = 1'b1;
          end
          CMD_TX_READY: begin
            tx_req.pop  = 1'b1;
            rd_pend_nxt = 1'b1;
          end
          CMD_POP_BYTE, CMD_POP_WORD: begin
            rx_req.pop  = 1'b1;
            rd_pend_nxt = 1'b1;
          end
          default: begin
          end
        endcase
        sh_nxt   = {sh_r[23:0], 8'h0};
        beat_nxt = beat_r + 2'd1;
        if (beat_r == last_r) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (slot_free) begin
          out_valid_nxt         = 1'b1;
          out_status_nxt        = status_r;
          out_read_data_nxt     = is_pop ? acc_nxt : '0;
          out_tx_valid_nxt      = (cmd_r == CMD_TX_READY) && (status_r == STAT_DONE);
          out_tx_byte_nxt       = (cmd_r == CMD_TX_READY) ? acc_nxt[7:0] : '0;
          out_tx_irq_enable_nxt = !tx_idle_r;
          out_rx_level_nxt      = LEVEL_W'(rx_count);
          out_tx_level_nxt      = LEVEL_W'(tx_count);
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_pend_r   <= 1'b0;
      tx_idle_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      tx_idle_r   <= tx_idle_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk) begin
    cmd_r               <= cmd_nxt;
    status_r            <= status_nxt;
    sh_r                <= sh_nxt;
    acc_r               <= acc_nxt;
    beat_r              <= beat_nxt;
    last_r              <= last_nxt;
    out_status_r        <= out_status_nxt;
    out_read_data_r     <= out_read_data_nxt;
    out_tx_valid_r      <= out_tx_valid_nxt;
    out_tx_byte_r       <= out_tx_byte_nxt;
    out_tx_irq_enable_r <= out_tx_irq_enable_nxt;
    out_rx_level_r      <= out_rx_level_nxt;
    out_tx_level_r      <= out_tx_level_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_read_data     = out_read_data_r;
  assign out_tx_valid      = out_tx_valid_r;
  assign out_tx_byte       = out_tx_byte_r;
  assign out_tx_irq_enable = out_tx_irq_enable_r;
  assign out_rx_level      = out_rx_level_r;
  assign out_tx_level      = out_tx_level_r;

endmodule

FILE: rtl/core/uart_rx_tx_byte_fifos_unit.sv
// UART receive and transmit byte FIFOs: top level.
// From accept, a query or a refused command goes straight to the result register;
// a byte operation first makes one access and a word push or pop makes four.
// A new command is taken only once the previous result word is registered; a word
// takes four accesses to the byte-wide FIFO memory, one per cycle.
// Reset (synchronous, active low) empties both FIFOs and sets the transmitter idle.
module uart_rx_tx_byte_fifos_unit import urtf_pkg::*; #(
  parameter int RX_DEPTH = DEF_RX_DEPTH,
  parameter int TX_DEPTH = DEF_TX_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [31:0]        in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [31:0]        out_read_data,
  output logic               out_tx_valid,
  output logic [7:0]         out_tx_byte,
  output logic               out_tx_irq_enable,
  output logic [LEVEL_W-1:0] out_rx_level,
  output logic [LEVEL_W-1:0] out_tx_level
);

  localparam int RAW = $clog2(RX_DEPTH);
  localparam int TAW = $clog2(TX_DEPTH);
  localparam int RCW = $clog2(RX_DEPTH + 1);
  localparam int TCW = $clog2(TX_DEPTH + 1);

  fifo_req_t      rx_req;
  fifo_req_t      tx_req;
  logic [RAW-1:0] rx_wr_slot, rx_rd_slot;
  logic [TAW-1:0] tx_wr_slot, tx_rd_slot;
  logic [RCW-1:0] rx_count;
  logic [TCW-1:0] tx_count;
  logic [7:0]     rx_q, tx_q;
  logic [7:0]     wr_byte;

  // Receive FIFO pointers and storage.
  urtf_ptrs #(.DEPTH(RX_DEPTH)) u_rx_ptrs (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (rx_req),
    .wr_slot (rx_wr_slot),
    .rd_slot (rx_rd_slot),
    .count   (rx_count)
  );

  urtf_ram #(.DEPTH(RX_DEPTH)) u_rx_ram (
    .clk     (clk),
    .wr_en   (rx_req.push),
    .wr_addr (rx_wr_slot),
    .wr_data (wr_byte),
    .rd_en   (rx_req.pop),
    .rd_addr (rx_rd_slot),
    .rd_data (rx_q)
  );

  // Transmit FIFO pointers and storage.
  urtf_ptrs #(.DEPTH(TX_DEPTH)) u_tx_ptrs (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (tx_req),
    .wr_slot (tx_wr_slot),
    .rd_slot (tx_rd_slot),
    .count   (tx_count)
  );

  urtf_ram #(.DEPTH(TX_DEPTH)) u_tx_ram (
    .clk     (clk),
    .wr_en   (tx_req.push),
    .wr_addr (tx_wr_slot),
    .wr_data (wr_byte),
    .rd_en   (tx_req.pop),
    .rd_addr (tx_rd_slot),
    .rd_data (tx_q)
  );

  // Command sequencer and result register.
  urtf_seq #(.RX_DEPTH(RX_DEPTH), .TX_DEPTH(TX_DEPTH)) u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_data           (in_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_read_data     (out_read_data),
    .out_tx_valid      (out_tx_valid),
    .out_tx_byte       (out_tx_byte),
    .out_tx_irq_enable (out_tx_irq_enable),
    .out_rx_level      (out_rx_level),
    .out_tx_level      (out_tx_level),
    .rx_count          (rx_count),
    .tx_count          (tx_count),
    .rx_q              (rx_q),
    .tx_q              (tx_q),
    .rx_req            (rx_req),
    .tx_req            (tx_req),
    .wr_byte           (wr_byte)
  );

endmodule
